// File: hdl/fbsm_pkg.sv
// ----------------------------------------------------------------------------
// fbsm_pkg
// Types, codes and helpers shared by the frame buffer swap manager.
// ----------------------------------------------------------------------------
`default_nettype none

package fbsm_pkg;

    localparam int NUM_SLOTS   = 3;
    localparam int SLOT_W      = 2;
    localparam int COUNT_W     = 6;
    localparam int CFG_DATA_W  = 6;

    typedef logic [SLOT_W-1:0]  slot_idx_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic [2:0] {
        ST_NONE     = 3'd0,
        ST_FREE     = 3'd1,
        ST_DRAWING  = 3'd2,
        ST_WAITDONE = 3'd3,
        ST_DRAWDONE = 3'd4,
        ST_NEXT     = 3'd5,
        ST_DISPLAY  = 3'd6,
        ST_COPYEFB  = 3'd7
    } slot_status_t;

    typedef slot_status_t status_vec_t [NUM_SLOTS];

    typedef enum logic [3:0] {
        FN_INIT         = 4'd0,
        FN_PRE_RETRACE  = 4'd1,
        FN_POST_RETRACE = 4'd2,
        FN_ACQUIRE      = 4'd3,
        FN_WAIT_DONE    = 4'd4,
        FN_DRAW_DONE    = 4'd5,
        FN_LAST         = 4'd6,
        FN_PENDING      = 4'd7,
        FN_CFG_CHANGE   = 4'd8,
        FN_EFB_DONE     = 4'd9
    } func_t;

    typedef enum logic {
        CFG_SLOT_MASK      = 1'b0,
        CFG_RETRACE_PERIOD = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] slot_present_mask;
        count_t               retrace_period;
    } cfg_t;

    typedef struct packed {
        logic [3:0] func;
        slot_idx_t  slot;
        logic       efb_cfg_flag;
    } item_t;

    typedef struct packed {
        logic      slot_found;
        slot_idx_t slot_index;
        logic      show_buffer;
        logic      reconfigure;
        logic      reconfig_from_efb;
        logic      flush_request;
        logic      copy_request;
        logic      pending;
        count_t    renew_rate;
        logic      error;
    } result_t;

    typedef struct packed {
        logic      found;
        slot_idx_t idx;
    } find_t;

    // lowest slot holding the given status
    function automatic find_t find_status(input status_vec_t sv, input slot_status_t st);
        find_t r;
        r = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (sv[i] == st) begin
                r.found = 1'b1;
                r.idx   = slot_idx_t'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/fbsm_cfg_regs.sv
// ----------------------------------------------------------------------------
// fbsm_cfg_regs
// Configuration register file: slot presence mask and measurement period.
// ----------------------------------------------------------------------------
`default_nettype none

module fbsm_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            wr_en,
    input  wire logic                            wr_index,
    input  wire logic [fbsm_pkg::CFG_DATA_W-1:0] wr_data,
    output fbsm_pkg::cfg_t                       cfg
);

    fbsm_pkg::cfg_t cfg_reg;
    fbsm_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                fbsm_pkg::CFG_SLOT_MASK:
                    cfg_next.slot_present_mask = wr_data[fbsm_pkg::NUM_SLOTS-1:0];
                fbsm_pkg::CFG_RETRACE_PERIOD:
                    cfg_next.retrace_period = wr_data[fbsm_pkg::COUNT_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slot_present_mask <= '1;
            cfg_reg.retrace_period    <= fbsm_pkg::count_t'(60);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: hdl/fbsm_engine.sv
// ----------------------------------------------------------------------------
// fbsm_engine
// Slot status table, render buffer flags and renew counters, with the
// combinational event logic that updates them and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module fbsm_engine (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    input  wire fbsm_pkg::item_t item,
    input  wire fbsm_pkg::cfg_t  cfg,
    output fbsm_pkg::result_t    res
);

    fbsm_pkg::status_vec_t                 status_reg, status_next;
    logic [fbsm_pkg::NUM_SLOTS-1:0]        slot_cfg_reg, slot_cfg_next;
    logic                                  pend_cfg_reg, pend_cfg_next;
    logic                                  efb_ready_reg, efb_ready_next;
    logic                                  efb_cfg_reg, efb_cfg_next;
    fbsm_pkg::count_t                      retrace_reg, retrace_next;
    fbsm_pkg::count_t                      renew_cnt_reg, renew_cnt_next;
    fbsm_pkg::count_t                      renew_res_reg, renew_res_next;

    always_comb
    begin
        fbsm_pkg::find_t   f_next;
        fbsm_pkg::find_t   f_disp;
        fbsm_pkg::find_t   f_free;
        fbsm_pkg::find_t   f_sel;
        fbsm_pkg::find_t   f_done;
        fbsm_pkg::result_t r;
        logic              renew;
        logic              one_slot;
        logic              slot_ok;

        status_next    = status_reg;
        slot_cfg_next  = slot_cfg_reg;
        pend_cfg_next  = pend_cfg_reg;
        efb_ready_next = efb_ready_reg;
        efb_cfg_next   = efb_cfg_reg;
        retrace_next   = retrace_reg;
        renew_cnt_next = renew_cnt_reg;
        renew_res_next = renew_res_reg;

        r        = '0;
        f_sel    = '0;
        renew    = 1'b0;
        one_slot = ($countones(cfg.slot_present_mask) == 1);
        slot_ok  = ({1'b0, item.slot} < (fbsm_pkg::SLOT_W + 1)'(fbsm_pkg::NUM_SLOTS));
        f_next   = fbsm_pkg::find_status(status_reg, fbsm_pkg::ST_NEXT);
        f_disp   = fbsm_pkg::find_status(status_reg, fbsm_pkg::ST_DISPLAY);
        f_free   = fbsm_pkg::find_status(status_reg, fbsm_pkg::ST_FREE);
        f_done   = fbsm_pkg::find_status(status_reg, fbsm_pkg::ST_DRAWDONE);

        case (item.func)
            fbsm_pkg::FN_INIT:
            begin
                for (int i = 0; i < fbsm_pkg::NUM_SLOTS; i++)
                begin
                    status_next[i] = cfg.slot_present_mask[i] ? fbsm_pkg::ST_FREE
                                                              : fbsm_pkg::ST_NONE;
                end
                slot_cfg_next  = '0;
                pend_cfg_next  = 1'b0;
                efb_ready_next = 1'b0;
                efb_cfg_next   = 1'b0;
                renew_res_next = '0;
                f_sel = fbsm_pkg::find_status(status_next, fbsm_pkg::ST_FREE);
            end
            fbsm_pkg::FN_PRE_RETRACE:
            begin
                if (f_next.found)
                begin
                    f_sel         = f_next;
                    r.show_buffer = 1'b1;
                    r.reconfigure = slot_cfg_reg[f_next.idx];
                    r.flush_request = 1'b1;
                    renew         = 1'b1;
                end
                else if (one_slot && efb_ready_reg)
                begin
                    // single buffer: reuse the shown slot, else take a free one
                    if (f_disp.found)
                    begin
                        f_sel = f_disp;
                    end
                    else
                    begin
                        f_sel = f_free;
                        if (f_free.found)
                        begin
                            r.show_buffer   = 1'b1;
                            r.flush_request = 1'b1;
                        end
                    end
                    if (f_sel.found)
                    begin
                        status_next[f_sel.idx] = fbsm_pkg::ST_COPYEFB;
                        if (efb_cfg_reg)
                        begin
                            r.reconfigure       = 1'b1;
                            r.reconfig_from_efb = 1'b1;
                            r.flush_request     = 1'b1;
                        end
                        renew = 1'b1;
                    end
                end
                renew_cnt_next = renew_cnt_reg + fbsm_pkg::count_t'(renew);
                retrace_next   = retrace_reg + 1'b1;
                if (retrace_next >= cfg.retrace_period)
                begin
                    renew_res_next = renew_cnt_next;
                    retrace_next   = '0;
                    renew_cnt_next = '0;
                end
            end
            fbsm_pkg::FN_POST_RETRACE:
            begin
                if (f_next.found)
                begin
                    if (f_disp.found)
                        status_next[f_disp.idx] = fbsm_pkg::ST_FREE;
                    status_next[f_next.idx] = fbsm_pkg::ST_DISPLAY;
                    // draw-done slots are untouched by the two writes above
                    if (f_done.found)
                        status_next[f_done.idx] = fbsm_pkg::ST_NEXT;
                    f_sel = f_next;
                end
                else
                begin
                    f_sel = fbsm_pkg::find_status(status_reg, fbsm_pkg::ST_COPYEFB);
                    if (f_sel.found)
                    begin
                        r.copy_request          = 1'b1;
                        status_next[f_sel.idx]  = fbsm_pkg::ST_DISPLAY;
                        efb_ready_next          = 1'b0;
                    end
                end
            end
            fbsm_pkg::FN_ACQUIRE:
            begin
                if ($countones(cfg.slot_present_mask) >= 2)
                begin
                    f_sel = fbsm_pkg::find_status(status_reg, fbsm_pkg::ST_DRAWING);
                    if (!f_sel.found)
                    begin
                        f_sel = f_free;
                        if (f_free.found)
                            status_next[f_free.idx] = fbsm_pkg::ST_DRAWING;
                    end
                end
            end
            fbsm_pkg::FN_WAIT_DONE:
            begin
                if (slot_ok && status_reg[item.slot] == fbsm_pkg::ST_DRAWING)
                begin
                    status_next[item.slot]   = fbsm_pkg::ST_WAITDONE;
                    slot_cfg_next[item.slot] = pend_cfg_reg;
                    pend_cfg_next            = 1'b0;
                    f_sel.found              = 1'b1;
                    f_sel.idx                = item.slot;
                end
                else
                begin
                    r.error = 1'b1;
                end
            end
            fbsm_pkg::FN_DRAW_DONE:
            begin
                if (slot_ok && status_reg[item.slot] == fbsm_pkg::ST_WAITDONE)
                begin
                    status_next[item.slot] = f_next.found ? fbsm_pkg::ST_DRAWDONE
                                                          : fbsm_pkg::ST_NEXT;
                    f_sel.found = 1'b1;
                    f_sel.idx   = item.slot;
                end
                else
                begin
                    r.error = 1'b1;
                end
            end
            fbsm_pkg::FN_LAST:
            begin
                f_sel = fbsm_pkg::find_status(status_reg, fbsm_pkg::ST_WAITDONE);
                if (!f_sel.found)
                    f_sel = f_done;
                if (!f_sel.found)
                    f_sel = f_next;
                if (!f_sel.found)
                    f_sel = f_disp;
            end
            fbsm_pkg::FN_PENDING:
            begin
                r.pending = fbsm_pkg::find_status(status_reg, fbsm_pkg::ST_WAITDONE).found
                            || f_done.found || f_next.found;
            end
            fbsm_pkg::FN_CFG_CHANGE:
            begin
                pend_cfg_next = 1'b1;
            end
            fbsm_pkg::FN_EFB_DONE:
            begin
                efb_ready_next = 1'b1;
                efb_cfg_next   = item.efb_cfg_flag;
            end
            default:
            begin
                f_sel = '0;
            end
        endcase

        r.slot_found  = f_sel.found;
        r.slot_index  = f_sel.found ? f_sel.idx : '0;
        r.renew_rate  = renew_res_next;
        res           = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fbsm_pkg::NUM_SLOTS; i++)
            begin
                status_reg[i] <= fbsm_pkg::ST_NONE;
            end
            slot_cfg_reg  <= '0;
            pend_cfg_reg  <= 1'b0;
            efb_ready_reg <= 1'b0;
            efb_cfg_reg   <= 1'b0;
            retrace_reg   <= '0;
            renew_cnt_reg <= '0;
            renew_res_reg <= '0;
        end
        else if (item_valid)
        begin
            status_reg    <= status_next;
            slot_cfg_reg  <= slot_cfg_next;
            pend_cfg_reg  <= pend_cfg_next;
            efb_ready_reg <= efb_ready_next;
            efb_cfg_reg   <= efb_cfg_next;
            retrace_reg   <= retrace_next;
            renew_cnt_reg <= renew_cnt_next;
            renew_res_reg <= renew_res_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/frame_buffer_swap_manager_top.sv
// ----------------------------------------------------------------------------
// frame_buffer_swap_manager_top
// Triple buffer swap chain manager: tracks display buffer slots and the
// render buffer, and answers one display/draw event per transfer.
// ----------------------------------------------------------------------------
// Usage
//   Event channel: drive func/slot/efb_cfg_flag with start high; the event
//   is taken at the rising edge where start is high and busy is low. busy
//   is held low, so one event can be taken every cycle.
//   Result channel: done is high for exactly one cycle, once the event has
//   passed the input register and then the result register; the result
//   fields are valid only in that cycle. Results leave in event order, one
//   per event. The receiver has no way to stall; it must take each result.
//   Throughput is one event per cycle, as the event logic is combinational
//   between the input register and the result register; the next event
//   sees the slot table as updated by the one before it.
//   Config channel: cfg_valid/cfg_ready with cfg_index (0 slot presence
//   mask, 1 retraces per period) and cfg_data; cfg_ready is always high.
//   Write it only while no event is in flight.
//   Reset: all slots read as none, flags and counters clear, mask = 7 and
//   period = 60. Send an init event before use to mark present slots free.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_buffer_swap_manager_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // event channel
    input  wire logic                            start,
    output      logic                            busy,
    input  wire logic [3:0]                      func,
    input  wire logic [fbsm_pkg::SLOT_W-1:0]     slot,
    input  wire logic                            efb_cfg_flag,
    // result channel
    output      logic                            done,
    output      logic                            slot_found,
    output      logic [fbsm_pkg::SLOT_W-1:0]     slot_index,
    output      logic                            show_buffer,
    output      logic                            reconfigure,
    output      logic                            reconfig_from_efb,
    output      logic                            flush_request,
    output      logic                            copy_request,
    output      logic                            pending,
    output      logic [fbsm_pkg::COUNT_W-1:0]    renew_rate,
    output      logic                            error,
    // configuration channel
    input  wire logic                            cfg_valid,
    output      logic                            cfg_ready,
    input  wire logic                            cfg_index,
    input  wire logic [fbsm_pkg::CFG_DATA_W-1:0] cfg_data
);

    // input register
    logic              in_valid_reg;
    fbsm_pkg::item_t   in_item_reg;
    fbsm_pkg::item_t   in_item_next;

    // result register
    logic              done_reg;
    fbsm_pkg::result_t res_reg;
    fbsm_pkg::result_t res_next;

    fbsm_pkg::cfg_t    cfg;
    logic              accept;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    assign in_item_next.func         = func;
    assign in_item_next.slot         = slot;
    assign in_item_next.efb_cfg_flag = efb_cfg_flag;

    fbsm_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    fbsm_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid_reg),
        .item       (in_item_reg),
        .cfg        (cfg),
        .res        (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
            done_reg     <= in_valid_reg;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= in_item_next;
        if (in_valid_reg)
            res_reg <= res_next;
    end

    assign done              = done_reg;
    assign slot_found        = res_reg.slot_found;
    assign slot_index        = res_reg.slot_index;
    assign show_buffer       = res_reg.show_buffer;
    assign reconfigure       = res_reg.reconfigure;
    assign reconfig_from_efb = res_reg.reconfig_from_efb;
    assign flush_request     = res_reg.flush_request;
    assign copy_request      = res_reg.copy_request;
    assign pending           = res_reg.pending;
    assign renew_rate        = res_reg.renew_rate;
    assign error             = res_reg.error;

endmodule

`default_nettype wire

// File: hdl/fbsm_checker.sv
// ----------------------------------------------------------------------------
// fbsm_checker
// Port-level checks for the frame buffer swap manager, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module fbsm_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         start,
    input wire logic                         busy,
    input wire logic                         done,
    input wire logic                         slot_found,
    input wire logic [fbsm_pkg::SLOT_W-1:0]  slot_index,
    input wire logic                         show_buffer,
    input wire logic                         flush_request,
    input wire logic                         copy_request,
    input wire logic                         error
);

    // every transfer in yields a result once it has passed the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("result missing two cycles after event transfer");

    // no result without an event transfer behind it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without a matching event transfer");

    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (!slot_found || error)) |-> (slot_index == '0 && !slot_found))
        else $error("slot_index set without a found slot");

    // a swap or a copy always names its slot and flushes on a swap
    a_show_copy: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (show_buffer || copy_request)) |->
            (slot_found && (flush_request || copy_request)))
        else $error("show/copy without a slot or without flush");

endmodule

bind frame_buffer_swap_manager_top fbsm_checker u_fbsm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .slot_found    (slot_found),
    .slot_index    (slot_index),
    .show_buffer   (show_buffer),
    .flush_request (flush_request),
    .copy_request  (copy_request),
    .error         (error)
);

`default_nettype wire

// File: tb/sv/fbsm_swap_checker.sv
// ----------------------------------------------------------------------------
// fbsm_swap_checker
// Watches the event, config and result channels of the swap manager, keeps
// its own slot table, and compares every result with the predicted one.
// ----------------------------------------------------------------------------
`default_nettype none

module fbsm_swap_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic                            busy,
    input  wire logic [3:0]                      func,
    input  wire logic [fbsm_pkg::SLOT_W-1:0]     slot,
    input  wire logic                            efb_cfg_flag,
    input  wire logic                            done,
    input  wire logic                            slot_found,
    input  wire logic [fbsm_pkg::SLOT_W-1:0]     slot_index,
    input  wire logic                            show_buffer,
    input  wire logic                            reconfigure,
    input  wire logic                            reconfig_from_efb,
    input  wire logic                            flush_request,
    input  wire logic                            copy_request,
    input  wire logic                            pending,
    input  wire logic [fbsm_pkg::COUNT_W-1:0]    renew_rate,
    input  wire logic                            error,
    input  wire logic                            cfg_valid,
    input  wire logic                            cfg_ready,
    input  wire logic                            cfg_index,
    input  wire logic [fbsm_pkg::CFG_DATA_W-1:0] cfg_data,
    output int unsigned                          failures,
    output int unsigned                          awaited,
    output int unsigned                          results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // predicted block state
    logic [fbsm_pkg::NUM_SLOTS-1:0] present_mask;
    fbsm_pkg::count_t               period;
    fbsm_pkg::slot_status_t         slot_state [fbsm_pkg::NUM_SLOTS];
    logic                           slot_changed [fbsm_pkg::NUM_SLOTS];
    logic                           changed_since_wait;
    logic                           render_ready;
    logic                           render_changed;
    fbsm_pkg::count_t               retraces;
    fbsm_pkg::count_t               renewed;
    fbsm_pkg::count_t               renew_shown;

    fbsm_pkg::result_t              awaited_results [$];

    task automatic reset_swap_state();
        present_mask       = '1;
        period             = fbsm_pkg::count_t'(60);
        changed_since_wait = 1'b0;
        render_ready       = 1'b0;
        render_changed     = 1'b0;
        retraces           = '0;
        renewed            = '0;
        renew_shown        = '0;
        for (int i = 0; i < fbsm_pkg::NUM_SLOTS; i++)
        begin
            slot_state[i]   = fbsm_pkg::ST_NONE;
            slot_changed[i] = 1'b0;
        end
    endtask

    function automatic int first_with(fbsm_pkg::slot_status_t st);
        for (int i = 0; i < fbsm_pkg::NUM_SLOTS; i++)
        begin
            if (slot_state[i] == st)
                return i;
        end
        return -1;
    endfunction

    function automatic int present_slots();
        int n;
        n = 0;
        for (int i = 0; i < fbsm_pkg::NUM_SLOTS; i++)
            n += int'(present_mask[i]);
        return n;
    endfunction

    // next result of the swap chain, updating the predicted state
    function automatic fbsm_pkg::result_t predict_swap(logic [3:0] fn,
                                                       fbsm_pkg::slot_idx_t sl,
                                                       logic flag);
        fbsm_pkg::result_t r;
        int                idx;
        int                d;
        logic              renew;
        r     = '0;
        idx   = -1;
        renew = 1'b0;
        case (fn)
            fbsm_pkg::FN_INIT:
            begin
                for (int i = 0; i < fbsm_pkg::NUM_SLOTS; i++)
                begin
                    slot_state[i]   = present_mask[i] ? fbsm_pkg::ST_FREE : fbsm_pkg::ST_NONE;
                    slot_changed[i] = 1'b0;
                end
                changed_since_wait = 1'b0;
                render_ready       = 1'b0;
                render_changed     = 1'b0;
                renew_shown        = '0;
                idx                = first_with(fbsm_pkg::ST_FREE);
            end
            fbsm_pkg::FN_PRE_RETRACE:
            begin
                idx = first_with(fbsm_pkg::ST_NEXT);
                if (idx >= 0)
                begin
                    r.show_buffer   = 1'b1;
                    r.reconfigure   = slot_changed[idx];
                    r.flush_request = 1'b1;
                    renew           = 1'b1;
                end
                else if (present_slots() == 1 && render_ready)
                begin
                    // single buffer: copy the render buffer into the shown or a free slot
                    idx = first_with(fbsm_pkg::ST_DISPLAY);
                    if (idx < 0)
                    begin
                        idx = first_with(fbsm_pkg::ST_FREE);
                        if (idx >= 0)
                        begin
                            r.show_buffer   = 1'b1;
                            r.flush_request = 1'b1;
                        end
                    end
                    if (idx >= 0)
                    begin
                        slot_state[idx] = fbsm_pkg::ST_COPYEFB;
                        if (render_changed)
                        begin
                            r.reconfigure       = 1'b1;
                            r.reconfig_from_efb = 1'b1;
                            r.flush_request     = 1'b1;
                        end
                        renew = 1'b1;
                    end
                end
                if (renew)
                    renewed = renewed + 1'b1;
                retraces = retraces + 1'b1;
                if (retraces >= period)
                begin
                    renew_shown = renewed;
                    retraces    = '0;
                    renewed     = '0;
                end
            end
            fbsm_pkg::FN_POST_RETRACE:
            begin
                idx = first_with(fbsm_pkg::ST_NEXT);
                if (idx >= 0)
                begin
                    d = first_with(fbsm_pkg::ST_DISPLAY);
                    if (d >= 0)
                        slot_state[d] = fbsm_pkg::ST_FREE;
                    slot_state[idx] = fbsm_pkg::ST_DISPLAY;
                    d = first_with(fbsm_pkg::ST_DRAWDONE);
                    if (d >= 0)
                        slot_state[d] = fbsm_pkg::ST_NEXT;
                end
                else
                begin
                    idx = first_with(fbsm_pkg::ST_COPYEFB);
                    if (idx >= 0)
                    begin
                        r.copy_request  = 1'b1;
                        slot_state[idx] = fbsm_pkg::ST_DISPLAY;
                        render_ready    = 1'b0;
                    end
                end
            end
            fbsm_pkg::FN_ACQUIRE:
            begin
                if (present_slots() >= 2)
                begin
                    idx = first_with(fbsm_pkg::ST_DRAWING);
                    if (idx < 0)
                    begin
                        idx = first_with(fbsm_pkg::ST_FREE);
                        if (idx >= 0)
                            slot_state[idx] = fbsm_pkg::ST_DRAWING;
                    end
                end
            end
            fbsm_pkg::FN_WAIT_DONE:
            begin
                if (int'(sl) < fbsm_pkg::NUM_SLOTS && slot_state[sl] == fbsm_pkg::ST_DRAWING)
                begin
                    slot_state[sl]     = fbsm_pkg::ST_WAITDONE;
                    slot_changed[sl]   = changed_since_wait;
                    changed_since_wait = 1'b0;
                    idx                = int'(sl);
                end
                else
                    r.error = 1'b1;
            end
            fbsm_pkg::FN_DRAW_DONE:
            begin
                if (int'(sl) < fbsm_pkg::NUM_SLOTS && slot_state[sl] == fbsm_pkg::ST_WAITDONE)
                begin
                    slot_state[sl] = (first_with(fbsm_pkg::ST_NEXT) >= 0) ? fbsm_pkg::ST_DRAWDONE
                                                                          : fbsm_pkg::ST_NEXT;
                    idx            = int'(sl);
                end
                else
                    r.error = 1'b1;
            end
            fbsm_pkg::FN_LAST:
            begin
                idx = first_with(fbsm_pkg::ST_WAITDONE);
                if (idx < 0)
                    idx = first_with(fbsm_pkg::ST_DRAWDONE);
                if (idx < 0)
                    idx = first_with(fbsm_pkg::ST_NEXT);
                if (idx < 0)
                    idx = first_with(fbsm_pkg::ST_DISPLAY);
            end
            fbsm_pkg::FN_PENDING:
                r.pending = first_with(fbsm_pkg::ST_WAITDONE) >= 0 ||
                            first_with(fbsm_pkg::ST_DRAWDONE) >= 0 ||
                            first_with(fbsm_pkg::ST_NEXT) >= 0;
            fbsm_pkg::FN_CFG_CHANGE:
                changed_since_wait = 1'b1;
            fbsm_pkg::FN_EFB_DONE:
            begin
                render_ready   = 1'b1;
                render_changed = flag;
            end
            default:
                ;
        endcase
        if (idx >= 0)
        begin
            r.slot_found = 1'b1;
            r.slot_index = fbsm_pkg::slot_idx_t'(idx);
        end
        r.renew_rate = renew_shown;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        failures++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      results_checked, name, got, want));
    endtask

    task automatic check_result();
        fbsm_pkg::result_t want;
        if (awaited_results.size() == 0)
            report_mismatch("result strobe with no event awaiting it");
        else
        begin
            want = awaited_results.pop_front();
            check_field("slot_found",        slot_found,        want.slot_found);
            check_field("slot_index",        slot_index,        want.slot_index);
            check_field("show_buffer",       show_buffer,       want.show_buffer);
            check_field("reconfigure",       reconfigure,       want.reconfigure);
            check_field("reconfig_from_efb", reconfig_from_efb, want.reconfig_from_efb);
            check_field("flush_request",     flush_request,     want.flush_request);
            check_field("copy_request",      copy_request,      want.copy_request);
            check_field("pending",           pending,           want.pending);
            check_field("renew_rate",        renew_rate,        want.renew_rate);
            check_field("error",             error,             want.error);
            results_checked++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_swap_state();
            awaited_results.delete();
            failures        = 0;
            awaited         = 0;
            results_checked = 0;
        end
        else
        begin
            if (done)
                check_result();
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == fbsm_pkg::CFG_SLOT_MASK)
                    present_mask = cfg_data[fbsm_pkg::NUM_SLOTS-1:0];
                else
                    period = fbsm_pkg::count_t'(cfg_data);
            end
            if (start && !busy)
                awaited_results.push_back(predict_swap(func, slot, efb_cfg_flag));
            awaited = unsigned'(awaited_results.size());
        end
    end

endmodule

`default_nettype wire

// File: tb/sv/frame_buffer_swap_manager_top_tb.sv
// ----------------------------------------------------------------------------
// frame_buffer_swap_manager_top_tb
// Drives display and draw events into the swap manager under a range of slot
// masks and retrace periods; a checker beside the block predicts each result.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_buffer_swap_manager_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // generous bound for the events of this bench and their idle gaps
    localparam int unsigned CYCLE_LIMIT   = 400000;
    // result register sits behind the input register; pad a little
    localparam int unsigned DRAIN_CYCLES  = 4;
    localparam int unsigned RANDOM_EVENTS = 800;
    localparam int          RANDOM_PHASES = 9;

    logic                            clk;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    logic [3:0]                      func;
    fbsm_pkg::slot_idx_t             slot;
    logic                            efb_cfg_flag;
    logic                            done;
    logic                            slot_found;
    fbsm_pkg::slot_idx_t             slot_index;
    logic                            show_buffer;
    logic                            reconfigure;
    logic                            reconfig_from_efb;
    logic                            flush_request;
    logic                            copy_request;
    logic                            pending;
    fbsm_pkg::count_t                renew_rate;
    logic                            error;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic                            cfg_index;
    logic [fbsm_pkg::CFG_DATA_W-1:0] cfg_data;

    int unsigned failures;
    int unsigned awaited;
    int unsigned results_checked;

    int unsigned events_sent;     // every transfer on the event channel
    int unsigned useful_sent;     // transfers with a defined func code
    int unsigned settings_used;
    int unsigned cycle_count;
    bit          no_idle;         // burst stretch: sender does not pause

    // ------------------------------------------------------------------
    // Clock: 12 ns period
    // ------------------------------------------------------------------
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    frame_buffer_swap_manager_top uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .func              (func),
        .slot              (slot),
        .efb_cfg_flag      (efb_cfg_flag),
        .done              (done),
        .slot_found        (slot_found),
        .slot_index        (slot_index),
        .show_buffer       (show_buffer),
        .reconfigure       (reconfigure),
        .reconfig_from_efb (reconfig_from_efb),
        .flush_request     (flush_request),
        .copy_request      (copy_request),
        .pending           (pending),
        .renew_rate        (renew_rate),
        .error             (error),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    // Checker sees the same pins as the block; it owns all prediction.
    fbsm_swap_checker checker_i (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .func              (func),
        .slot              (slot),
        .efb_cfg_flag      (efb_cfg_flag),
        .done              (done),
        .slot_found        (slot_found),
        .slot_index        (slot_index),
        .show_buffer       (show_buffer),
        .reconfigure       (reconfigure),
        .reconfig_from_efb (reconfig_from_efb),
        .flush_request     (flush_request),
        .copy_request      (copy_request),
        .pending           (pending),
        .renew_rate        (renew_rate),
        .error             (error),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .failures          (failures),
        .awaited           (awaited),
        .results_checked   (results_checked)
    );

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still awaited",
                     cycle_count, awaited);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // One event transfer. Called at a falling edge, returns at a falling
    // edge with start still high, so a back-to-back event just swaps the
    // fields and start never drops and rises in the same step.
    // ------------------------------------------------------------------
    task automatic send_event(input logic [3:0] f, input fbsm_pkg::slot_idx_t s,
                              input logic fl);
        int gap;
        if ($urandom_range(0, 59) == 0)
            no_idle = !no_idle;
        gap = no_idle ? 0 : int'($urandom_range(0, 13));
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start        <= 1'b1;
        func         <= f;
        slot         <= s;
        efb_cfg_flag <= fl;
        // transfer happens at the rising edge with busy low
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        events_sent++;
        if (f <= fbsm_pkg::FN_EFB_DONE)
            useful_sent++;
    endtask

    // Stop the event channel and wait until every result has come back,
    // plus the pipeline depth so the block is truly idle.
    task automatic drain_events();
        start <= 1'b0;
        while (awaited != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write both registers back to back; only done on an idle block.
    task automatic set_config(input logic [fbsm_pkg::CFG_DATA_W-1:0] mask_data,
                              input logic [fbsm_pkg::CFG_DATA_W-1:0] period_data);
        drain_events();
        cfg_valid <= 1'b1;
        cfg_index <= fbsm_pkg::CFG_SLOT_MASK;
        cfg_data  <= mask_data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_index <= fbsm_pkg::CFG_RETRACE_PERIOD;
        cfg_data  <= period_data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Sweep a slot event over all three slots from a random start: one of
    // them usually hits the slot in the right state, the others flag errors.
    task automatic sweep_slots(input logic [3:0] f);
        int first;
        first = int'($urandom_range(0, 2));
        for (int k = 0; k < 3; k++)
            send_event(f, fbsm_pkg::slot_idx_t'((first + k) % 3), 1'($urandom_range(0, 1)));
    endtask

    // ------------------------------------------------------------------
    // Random traffic: mostly complete draw/flip frames, some render buffer
    // copy cycles, occasional re-init and raw noise over every field value.
    // ------------------------------------------------------------------
    task automatic run_random(input int unsigned target);
        int unsigned pick;
        while (useful_sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_event(fbsm_pkg::FN_CFG_CHANGE, 2'd0, 1'b0);
                send_event(fbsm_pkg::FN_ACQUIRE, 2'd0, 1'b0);
                sweep_slots(fbsm_pkg::FN_WAIT_DONE);
                sweep_slots(fbsm_pkg::FN_DRAW_DONE);
                repeat ($urandom_range(0, 2))
                begin
                    send_event(fbsm_pkg::FN_PRE_RETRACE, 2'd0, 1'b0);
                    send_event(fbsm_pkg::FN_POST_RETRACE, 2'd0, 1'b0);
                end
                if ($urandom_range(0, 2) == 0)
                    send_event(fbsm_pkg::FN_LAST, 2'd0, 1'b0);
                if ($urandom_range(0, 2) == 0)
                    send_event(fbsm_pkg::FN_PENDING, 2'd0, 1'b0);
            end
            else if (pick < 75)
            begin
                send_event(fbsm_pkg::FN_EFB_DONE,
                           fbsm_pkg::slot_idx_t'($urandom_range(0, 3)),
                           1'($urandom_range(0, 1)));
                send_event(fbsm_pkg::FN_PRE_RETRACE, 2'd0, 1'b0);
                send_event(fbsm_pkg::FN_POST_RETRACE, 2'd0, 1'b0);
            end
            else if (pick < 79)
                send_event(fbsm_pkg::FN_INIT, 2'd0, 1'b0);
            else
                send_event(4'($urandom_range(0, 15)),
                           fbsm_pkg::slot_idx_t'($urandom_range(0, 3)),
                           1'($urandom_range(0, 1)));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [fbsm_pkg::CFG_DATA_W-1:0] mask_tab   [RANDOM_PHASES];
        logic [fbsm_pkg::CFG_DATA_W-1:0] period_tab [RANDOM_PHASES];

        // masks cover all-present, none, single and pairs; periods cover 1, PAL,
        // NTSC and the 6-bit top; the last phase draws both at random
        mask_tab   = '{6'd7, 6'd3, 6'd0, 6'd5, 6'd6, 6'd2, 6'd1, 6'd4, 6'd0};
        period_tab = '{6'd63, 6'd1, 6'd5, 6'd60, 6'd4, 6'd50, 6'd3, 6'd2, 6'd0};
        mask_tab[RANDOM_PHASES-1]   = fbsm_pkg::CFG_DATA_W'($urandom_range(0, 63));
        period_tab[RANDOM_PHASES-1] = fbsm_pkg::CFG_DATA_W'($urandom_range(0, 63));

        start         = 1'b0;
        func          = fbsm_pkg::FN_INIT;
        slot          = '0;
        efb_cfg_flag  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = fbsm_pkg::CFG_SLOT_MASK;
        cfg_data      = '0;
        rst_n         = 1'b0;
        events_sent   = 0;
        useful_sent   = 0;
        settings_used = 0;
        cycle_count   = 0;
        no_idle       = 1'b0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // --- three slots, short period so renew_rate moves ---
        set_config(6'd7, 6'd2);
        send_event(fbsm_pkg::FN_PENDING, 2'd0, 1'b0);       // all slots none before init
        send_event(fbsm_pkg::FN_INIT, 2'd0, 1'b0);
        send_event(fbsm_pkg::FN_WAIT_DONE, 2'd3, 1'b0);     // slot number out of range
        send_event(fbsm_pkg::FN_DRAW_DONE, 2'd0, 1'b1);     // slot free, wrong state
        send_event(fbsm_pkg::FN_ACQUIRE, 2'd0, 1'b0);
        send_event(fbsm_pkg::FN_ACQUIRE, 2'd0, 1'b0);       // same drawing slot again
        send_event(fbsm_pkg::FN_CFG_CHANGE, 2'd0, 1'b0);
        send_event(fbsm_pkg::FN_WAIT_DONE, 2'd0, 1'b0);     // picks up the change mark
        send_event(fbsm_pkg::FN_LAST, 2'd0, 1'b0);
        send_event(fbsm_pkg::FN_PENDING, 2'd0, 1'b0);
        send_event(fbsm_pkg::FN_DRAW_DONE, 2'd0, 1'b0);     // becomes next
        send_event(fbsm_pkg::FN_ACQUIRE, 2'd0, 1'b0);
        send_event(fbsm_pkg::FN_WAIT_DONE, 2'd1, 1'b0);
        send_event(fbsm_pkg::FN_DRAW_DONE, 2'd1, 1'b0);     // next taken: draw-done
        send_event(fbsm_pkg::FN_PRE_RETRACE, 2'd0, 1'b0);   // show with reconfigure
        send_event(fbsm_pkg::FN_POST_RETRACE, 2'd0, 1'b0);  // promote draw-done to next
        send_event(fbsm_pkg::FN_PRE_RETRACE, 2'd0, 1'b0);
        send_event(fbsm_pkg::FN_POST_RETRACE, 2'd0, 1'b0);  // old display back to free
        send_event(fbsm_pkg::FN_EFB_DONE, 2'd2, 1'b1);
        send_event(4'd15, 2'd3, 1'b1);                      // undefined func code
        send_event(fbsm_pkg::FN_LAST, 2'd0, 1'b0);

        // --- single buffer, zero period; mask write carries junk high bits ---
        set_config(6'b111_001, 6'd0);
        send_event(fbsm_pkg::FN_INIT, 2'd0, 1'b0);
        send_event(fbsm_pkg::FN_EFB_DONE, 2'd0, 1'b1);
        send_event(fbsm_pkg::FN_PRE_RETRACE, 2'd0, 1'b0);   // free slot: copy from render
        send_event(fbsm_pkg::FN_EFB_DONE, 2'd0, 1'b0);
        send_event(fbsm_pkg::FN_PRE_RETRACE, 2'd0, 1'b0);   // no display and no free slot
        send_event(fbsm_pkg::FN_POST_RETRACE, 2'd0, 1'b0);  // copy request
        send_event(fbsm_pkg::FN_PRE_RETRACE, 2'd0, 1'b0);   // render buffer not ready
        send_event(fbsm_pkg::FN_ACQUIRE, 2'd0, 1'b0);       // one buffer: nothing to hand out

        // --- random phases over a spread of settings ---
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_config(mask_tab[p], period_tab[p]);
            // now and then keep the old slot table across a mask change
            if ($urandom_range(0, 3) != 0)
                send_event(fbsm_pkg::FN_INIT, 2'd0, 1'b0);
            run_random(useful_sent + RANDOM_EVENTS / RANDOM_PHASES);
        end

        drain_events();

        $display("covered %0d events (%0d with defined codes) across %0d register settings",
                 events_sent, useful_sent, settings_used);
        $display("compared %0d results, %0d mismatches", results_checked, failures);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
hdl/fbsm_pkg.sv
hdl/fbsm_cfg_regs.sv
hdl/fbsm_engine.sv
hdl/frame_buffer_swap_manager_top.sv
hdl/fbsm_checker.sv
tb/sv/fbsm_swap_checker.sv
tb/sv/frame_buffer_swap_manager_top_tb.sv
